@@ src/hnc_pkg.sv @@
`default_nettype none
package hnc_pkg;

	// field widths
	localparam int WORD_W  = 32;
	localparam int CIDX_W  = 6;
	localparam int WIDX_W  = 3;
	localparam int DIST_W  = 9;
	localparam int PCNT_W  = 6;
	localparam int CNT_W   = 7;
	localparam int VW_W    = 4;

	// addressable slots of the input fields
	localparam int INDEX_SLOTS = 64;
	localparam int WORD_SLOTS  = 8;

	localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

	// stream packing
	localparam int S_DATA_W = 48;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_WORDS   = 2'd1;

	localparam logic [CNT_W-1:0] CENTROID_COUNT_RESET = 7'd1;
	localparam logic [VW_W-1:0]  VECTOR_WORDS_RESET   = 4'd8;

	// opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

endpackage
`default_nettype wire

@@ src/hnc_popcount.sv @@
`default_nettype none
module hnc_popcount (
	input  wire logic [hnc_pkg::WORD_W-1:0] x,
	output logic      [hnc_pkg::PCNT_W-1:0] count
);
	import hnc_pkg::*;

	logic [WORD_W-1:0] pairs;
	logic [WORD_W-1:0] nibbles;
	logic [WORD_W-1:0] bytes;

	// sum bits in pairs, then nibbles, then bytes
	always_comb begin
		pairs   = x - ((x >> 1) & 32'h5555_5555);
		nibbles = (pairs & 32'h3333_3333) + ((pairs >> 2) & 32'h3333_3333);
		bytes   = (nibbles + (nibbles >> 4)) & 32'h0F0F_0F0F;
		count   = PCNT_W'(bytes[7:0]) + PCNT_W'(bytes[15:8])
			+ PCNT_W'(bytes[23:16]) + PCNT_W'(bytes[31:24]);
	end

endmodule
`default_nettype wire

@@ src/hamming_nearest_centroid.sv @@
`default_nettype none
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: index, word pos, word; tuser: op
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: nearest index, distance
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A load word is written straight into the centroid memory when it is accepted.
// A query word for N active centroids is accepted, then each centroid gets one distance memory
// and one centroid memory read and passes two stages of popcount and accumulate, and the
// block returns to idle once the pipeline has drained.
// Running distances are cleared through per-entry valid flags, so reset needs no pass.
// A final query word waits before its sweep while the previous result is still held.
module hamming_nearest_centroid #(
	parameter int MAX_CENTROIDS = 64,
	parameter int MAX_WORDS     = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: centroid_index[5:0], word_index[8:6], word_value[40:9], zero fill[47:41]
	input  wire logic [hnc_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// tuser: opcode[0]
	input  wire logic [hnc_pkg::S_USER_W-1:0]   s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// tdata: nearest_index[5:0], nearest_distance[14:6], zero fill[15]
	output logic      [hnc_pkg::M_DATA_W-1:0]   m_axis_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [hnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hnc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hnc_pkg::*;

	localparam int CLIM  = (MAX_CENTROIDS < INDEX_SLOTS) ? MAX_CENTROIDS : INDEX_SLOTS;
	localparam int WLIM  = (MAX_WORDS < WORD_SLOTS) ? MAX_WORDS : WORD_SLOTS;
	localparam int SDEPTH = MAX_CENTROIDS * MAX_WORDS;
	localparam int SAW   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int DAW   = (CLIM > 1) ? $clog2(CLIM) : 1;

	// input fields
	logic [CIDX_W-1:0] in_cidx;
	logic [WIDX_W-1:0] in_widx;
	logic [WORD_W-1:0] in_word;
	logic              in_op;
	logic              in_acc;

	assign in_cidx = s_axis_tdata[5:0];
	assign in_widx = s_axis_tdata[8:6];
	assign in_word = s_axis_tdata[40:9];
	assign in_op   = s_axis_tuser[0];

	// configuration
	logic [CNT_W-1:0] cc_q;
	logic [VW_W-1:0]  vw_q;
	logic [CNT_W-1:0] nc;
	logic [VW_W-1:0]  nw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CENTROID_COUNT_RESET;
			vw_q <= VECTOR_WORDS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CENTROID_COUNT)
				cc_q <= cfg_data;
			else if (cfg_index == REG_VECTOR_WORDS)
				vw_q <= cfg_data[VW_W-1:0];
		end
	end

	// clamp counts to the range from one to the table size
	always_comb begin
		nc = cc_q;
		if (cc_q == '0)
			nc = CNT_W'(1);
		else if (cc_q > CNT_W'(CLIM))
			nc = CNT_W'(CLIM);
		nw = vw_q;
		if (vw_q == '0)
			nw = VW_W'(1);
		else if (vw_q > VW_W'(WLIM))
			nw = VW_W'(WLIM);
	end

	// control
	state_t            st_q;
	logic [CNT_W-1:0]  c_q;
	logic [SAW-1:0]    base_q;
	logic [WORD_W-1:0] word_q;
	logic [WIDX_W-1:0] widx_q;
	logic              last_q;
	logic              issue;
	logic              is_final;
	logic              q_ok;
	logic              ld_ok;

	logic              v_s1, v_s2;
	logic              first_s1, first_s2;
	logic              final_s1, final_s2;
	logic [DAW-1:0]    c_s1, c_s2;
	logic              out_valid_q;
	logic              done_s2;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign q_ok          = ({1'b0, in_widx} < nw);
	assign ld_ok         = (32'(in_cidx) < MAX_CENTROIDS) && (32'(in_widx) < MAX_WORDS);
	assign issue         = (st_q == ST_SWEEP) && !(last_q && out_valid_q);
	assign is_final      = (c_q == nc - CNT_W'(1));
	assign done_s2       = v_s2 && final_s2 && last_q;

	// sequence the sweep over active centroids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			c_q    <= '0;
			base_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc && in_op == OP_QUERY && q_ok) begin
						st_q   <= ST_SWEEP;
						c_q    <= '0;
						base_q <= '0;
					end
				end
				ST_SWEEP: begin
					if (issue) begin
						c_q    <= c_q + CNT_W'(1);
						base_q <= SAW'(32'(base_q) + MAX_WORDS);
						if (is_final)
							st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// latch the query word
	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_QUERY) begin
			word_q <= in_word;
			widx_q <= in_widx;
			last_q <= ({1'b0, in_widx} == nw - VW_W'(1));
		end
	end

	// centroid memory
	logic [WORD_W-1:0] store_mem [SDEPTH];
	logic [WORD_W-1:0] store_rd_q;
	logic [SAW-1:0]    ld_addr;
	logic [SAW-1:0]    rd_addr;

	assign ld_addr = SAW'(32'(in_cidx) * MAX_WORDS + 32'(in_widx));
	assign rd_addr = SAW'(32'(base_q) + 32'(widx_q));

	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_LOAD && ld_ok)
			store_mem[ld_addr] <= in_word;
		if (issue)
			store_rd_q <= store_mem[rd_addr];
	end

	// running distance memory with per-entry valid flags
	logic [DIST_W-1:0] dist_mem [CLIM];
	logic [DIST_W-1:0] dist_rd_q;
	logic [CLIM-1:0]   dvalid_q;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] sat;

	always_ff @(posedge clk) begin
		if (issue)
			dist_rd_q <= dist_mem[c_q[DAW-1:0]];
		if (v_s2)
			dist_mem[c_s2] <= sat;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			dvalid_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			// drop all partial distances once the query is reported
			if (done_s2)
				dvalid_q <= '0;
			else if (v_s2)
				dvalid_q[c_s2] <= 1'b1;
		end
	end

	// stage 1: popcount of the difference, fetch the partial distance
	logic [PCNT_W-1:0] pc;
	logic [PCNT_W-1:0] pc_s2;
	logic [DIST_W-1:0] dist_s2;

	hnc_popcount u_popcount (
		.x     (word_q ^ store_rd_q),
		.count (pc)
	);

	always_ff @(posedge clk) begin
		c_s1     <= c_q[DAW-1:0];
		first_s1 <= (c_q == '0);
		final_s1 <= is_final;
		c_s2     <= c_s1;
		first_s2 <= first_s1;
		final_s2 <= final_s1;
		pc_s2    <= pc;
		dist_s2  <= dvalid_q[c_s1] ? dist_rd_q : '0;
	end

	// stage 2: accumulate with saturation, track the minimum
	logic [DIST_W-1:0] best_q;
	logic [CIDX_W-1:0] bidx_q;
	logic [DIST_W-1:0] new_best;
	logic [CIDX_W-1:0] new_bidx;
	logic [CIDX_W-1:0] out_idx_q;
	logic [DIST_W-1:0] out_dist_q;

	always_comb begin
		sum = {1'b0, dist_s2} + (DIST_W+1)'(pc_s2);
		sat = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
		new_best = best_q;
		new_bidx = bidx_q;
		if (first_s2 || sat < best_q) begin
			new_best = sat;
			new_bidx = CIDX_W'(c_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			best_q <= new_best;
			bidx_q <= new_bidx;
		end
		if (done_s2) begin
			out_idx_q  <= new_bidx;
			out_dist_q <= new_best;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_s2)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_dist_q, out_idx_q};

`ifndef SYNTH
	// a final word never starts reading while the previous result is held
	a_no_issue_over_result: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_q) |-> !out_valid_q)
		else $error("final query word issued while a result is pending");

	// the pipeline only runs while the block is busy
	a_busy_while_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (st_q != ST_IDLE))
		else $error("pipeline active while idle");

	// the write-back never hits the entry being read
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && v_s2) |-> (c_q[DAW-1:0] != c_s2))
		else $error("distance read and write to the same entry");

	// all partial distances are cleared after a result
	a_cleared_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 |=> (dvalid_q == '0) && out_valid_q)
		else $error("distances not cleared after result");
`endif

endmodule
`default_nettype wire
